### rtl/gsfo_pkg.sv
// Shared constants, vector types and the rounding helper for the Gram-Schmidt
// frame orthonormalizer. No dependencies; used by every other file in rtl/.
`default_nettype none

package gsfo_pkg;

  localparam int UW   = 32;  // input and unit-vector component width
  localparam int VW   = 36;  // residual component width
  localparam int DW   = 34;  // dot product width
  localparam int MW   = 35;  // residual magnitude width
  localparam int NW   = 31;  // normalized magnitude width
  localparam int SQW  = 64;  // sum of squares width
  localparam int RTW  = 32;  // square root width
  localparam int QW   = 31;  // quotient width
  localparam int PW   = 66;  // wide product and sum width
  localparam int FRAC = 30;
  localparam int NUMW = NW + FRAC + 1;

  localparam int SQRT_STEPS = RTW;
  localparam int DIV_STEPS  = QW;
  localparam int UNIT_LAT   = 7 + SQRT_STEPS + 1 + DIV_STEPS + 1;
  localparam int PROJ_LAT   = 6;

  localparam logic [UW-1:0] UNIT_ONE = 32'h4000_0000;

  typedef logic [2:0][UW-1:0] vec32_t;
  typedef logic [2:0][VW-1:0] vec36_t;

  // Shift right by 30 with rounding half away from zero.
  function automatic logic signed [VW-1:0] rnd30(input logic signed [PW-1:0] x);
    logic signed [PW-1:0] t;
    t = x + $signed({{(PW-FRAC){1'b0}}, (x[PW-1] ? 30'h1FFF_FFFF : 30'h2000_0000)});
    return t[PW-1:FRAC];
  endfunction

  function automatic vec36_t ext_vec(input vec32_t v);
    vec36_t r;
    for (int i = 0; i < 3; i++) begin
      r[i] = VW'($signed(v[i]));
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/gsfo_unit.sv
// Pipelined vector normalizer: magnitude, block normalization, sum of squares,
// bit-serial square root and restoring division per component. Uses gsfo_pkg.
`default_nettype none

module gsfo_unit import gsfo_pkg::*; #(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  vec36_t            in_vec,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output vec32_t            out_vec,
  output logic              out_zero,
  output logic [SIDE_W-1:0] out_side
);

  localparam int CW = SIDE_W + 4;

  logic [UNIT_LAT-1:0] vld_r;
  logic [CW-1:0]       cl_r [UNIT_LAT];
  logic [CW-1:0]       cl_nxt;

  always_comb begin
    cl_nxt = {in_side, in_vec[2][VW-1], in_vec[1][VW-1], in_vec[0][VW-1], in_vec == '0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[UNIT_LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    cl_r[0] <= cl_nxt;
    for (int i = 1; i < UNIT_LAT; i++) begin
      cl_r[i] <= cl_r[i-1];
    end
  end

  logic [2:0][MW-1:0] mag_r, mag_nxt;
  logic [2:0][MW-1:0] m1_r, m2_r, m2_nxt, m3_r, m3_nxt;
  logic [MW-1:0]      top1_r, top1_nxt, top2_r, top2_nxt, top3_r, top3_nxt;
  logic [2:0][NW-1:0] m4_r, m4_nxt, m5_r;
  logic [2:0][2*NW-1:0] sq_r, sq_nxt;
  logic [SQW-1:0]     sum_nxt;

  always_comb begin
    logic [VW-1:0] neg;
    neg = '0;
    for (int i = 0; i < 3; i++) begin
      neg = '0 - in_vec[i];
      mag_nxt[i] = in_vec[i][VW-1] ? neg[MW-1:0] : in_vec[i][MW-1:0];
    end
  end

  always_comb begin
    top1_nxt = mag_r[0];
    if (mag_r[1] > top1_nxt) begin
      top1_nxt = mag_r[1];
    end
    if (mag_r[2] > top1_nxt) begin
      top1_nxt = mag_r[2];
    end
  end

  always_comb begin
    m2_nxt   = m1_r;
    top2_nxt = top1_r;
    if (top2_nxt[MW-1:33] != '0) begin
      top2_nxt = top2_nxt >> 2;
      for (int i = 0; i < 3; i++) m2_nxt[i] = m2_nxt[i] >> 2;
    end
    if (top2_nxt[MW-1:32] != '0) begin
      top2_nxt = top2_nxt >> 1;
      for (int i = 0; i < 3; i++) m2_nxt[i] = m2_nxt[i] >> 1;
    end
    if (top2_nxt[MW-1:31] != '0) begin
      top2_nxt = top2_nxt >> 1;
      for (int i = 0; i < 3; i++) m2_nxt[i] = m2_nxt[i] >> 1;
    end
  end

  always_comb begin
    m3_nxt   = m2_r;
    top3_nxt = top2_r;
    if (top3_nxt[MW-1:15] == '0) begin
      top3_nxt = top3_nxt << 16;
      for (int i = 0; i < 3; i++) m3_nxt[i] = m3_nxt[i] << 16;
    end
    if (top3_nxt[MW-1:23] == '0) begin
      top3_nxt = top3_nxt << 8;
      for (int i = 0; i < 3; i++) m3_nxt[i] = m3_nxt[i] << 8;
    end
    if (top3_nxt[MW-1:27] == '0) begin
      top3_nxt = top3_nxt << 4;
      for (int i = 0; i < 3; i++) m3_nxt[i] = m3_nxt[i] << 4;
    end
  end

  always_comb begin
    logic [2:0][MW-1:0] mm;
    logic [MW-1:0]      tm;
    mm = m3_r;
    tm = top3_r;
    if (tm[MW-1:29] == '0) begin
      tm = tm << 2;
      for (int i = 0; i < 3; i++) mm[i] = mm[i] << 2;
    end
    if (tm[MW-1:30] == '0) begin
      for (int i = 0; i < 3; i++) mm[i] = mm[i] << 1;
    end
    for (int i = 0; i < 3; i++) begin
      m4_nxt[i] = mm[i][NW-1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_nxt[i] = m4_r[i] * m4_r[i];
    end
    sum_nxt = SQW'(sq_r[0]) + SQW'(sq_r[1]) + SQW'(sq_r[2]);
  end

  logic [SQW-1:0]     sr_rem_r  [SQRT_STEPS+1];
  logic [RTW-1:0]     sr_root_r [SQRT_STEPS+1];
  logic [2:0][NW-1:0] sr_m_r    [SQRT_STEPS+1];

  always_ff @(posedge clk) begin
    mag_r  <= mag_nxt;
    m1_r   <= mag_r;
    top1_r <= top1_nxt;
    m2_r   <= m2_nxt;
    top2_r <= top2_nxt;
    m3_r   <= m3_nxt;
    top3_r <= top3_nxt;
    m4_r   <= m4_nxt;
    sq_r   <= sq_nxt;
    m5_r   <= m4_r;
    sr_rem_r[0]  <= sum_nxt;
    sr_root_r[0] <= '0;
    sr_m_r[0]    <= m5_r;
  end

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    localparam int K = SQRT_STEPS - 1 - j;
    logic [SQW+1:0] trial;
    logic [SQW-1:0] rem_nxt;
    logic [RTW-1:0] root_nxt;

    always_comb begin
      trial = ((SQW+2)'(sr_root_r[j]) << (K + 1)) + ((SQW+2)'(1) << (2 * K));
      if ({2'b00, sr_rem_r[j]} >= trial) begin
        rem_nxt  = sr_rem_r[j] - trial[SQW-1:0];
        root_nxt = sr_root_r[j] | (RTW'(1) << K);
      end else begin
        rem_nxt  = sr_rem_r[j];
        root_nxt = sr_root_r[j];
      end
    end

    always_ff @(posedge clk) begin
      sr_rem_r[j+1]  <= rem_nxt;
      sr_root_r[j+1] <= root_nxt;
      sr_m_r[j+1]    <= sr_m_r[j];
    end
  end

  logic [2:0][NUMW-1:0] dv_num_r [DIV_STEPS+1];
  logic [RTW-1:0]       dv_n_r   [DIV_STEPS+1];
  logic [2:0][RTW-1:0]  dv_rem_r [DIV_STEPS+1];
  logic [2:0][QW-1:0]   dv_q_r   [DIV_STEPS+1];
  logic [2:0][NUMW-1:0] num_nxt;
  logic [2:0][RTW-1:0]  rem0_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num_nxt[i]  = NUMW'({sr_m_r[SQRT_STEPS][i], {FRAC{1'b0}}})
                  + NUMW'(sr_root_r[SQRT_STEPS] >> 1);
      rem0_nxt[i] = RTW'(num_nxt[i][NUMW-1:QW]);
    end
  end

  always_ff @(posedge clk) begin
    dv_num_r[0] <= num_nxt;
    dv_n_r[0]   <= sr_root_r[SQRT_STEPS];
    dv_rem_r[0] <= rem0_nxt;
    dv_q_r[0]   <= '0;
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    localparam int K = DIV_STEPS - 1 - j;
    logic [2:0][RTW-1:0] rem_nxt;
    logic [2:0][QW-1:0]  q_nxt;

    always_comb begin
      logic [RTW:0] sh;
      sh = '0;
      for (int i = 0; i < 3; i++) begin
        sh = {dv_rem_r[j][i], dv_num_r[j][i][K]};
        if (sh >= {1'b0, dv_n_r[j]}) begin
          rem_nxt[i] = RTW'(sh - {1'b0, dv_n_r[j]});
          q_nxt[i]   = dv_q_r[j][i] | (QW'(1) << K);
        end else begin
          rem_nxt[i] = sh[RTW-1:0];
          q_nxt[i]   = dv_q_r[j][i];
        end
      end
    end

    always_ff @(posedge clk) begin
      dv_num_r[j+1] <= dv_num_r[j];
      dv_n_r[j+1]   <= dv_n_r[j];
      dv_rem_r[j+1] <= rem_nxt;
      dv_q_r[j+1]   <= q_nxt;
    end
  end

  vec32_t fin_r, fin_nxt;

  always_comb begin
    logic [UW-1:0] qs;
    qs = '0;
    for (int i = 0; i < 3; i++) begin
      qs = ({1'b0, dv_q_r[DIV_STEPS][i]} > UNIT_ONE) ? UNIT_ONE
         : {1'b0, dv_q_r[DIV_STEPS][i]};
      if (cl_r[UNIT_LAT-2][0]) begin
        fin_nxt[i] = '0;
      end else if (cl_r[UNIT_LAT-2][1+i]) begin
        fin_nxt[i] = '0 - qs;
      end else begin
        fin_nxt[i] = qs;
      end
    end
  end

  always_ff @(posedge clk) begin
    fin_r <= fin_nxt;
  end

  assign out_valid = vld_r[UNIT_LAT-1];
  assign out_vec   = fin_r;
  assign out_zero  = cl_r[UNIT_LAT-1][0];
  assign out_side  = cl_r[UNIT_LAT-1][CW-1:4];

endmodule

`default_nettype wire

### rtl/gsfo_proj.sv
// Pipelined projection removal: dot product of a unit vector with x, then
// y minus the rounded projection on that unit vector. Uses gsfo_pkg.
`default_nettype none

module gsfo_proj import gsfo_pkg::*; #(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  vec32_t            in_u,
  input  vec32_t            in_x,
  input  vec36_t            in_y,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output vec36_t            out_w,
  output logic [SIDE_W-1:0] out_side
);

  logic [PROJ_LAT-1:0] vld_r;
  logic [SIDE_W-1:0]   sd_r [PROJ_LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[PROJ_LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    sd_r[0] <= in_side;
    for (int i = 1; i < PROJ_LAT; i++) begin
      sd_r[i] <= sd_r[i-1];
    end
  end

  logic signed [2*UW-1:0] p_r [3];
  logic signed [PW-1:0]   sum_r;
  logic signed [DW-1:0]   d_r;
  logic signed [PW-1:0]   q_r [3];
  logic signed [VW-1:0]   r_r [3];
  vec32_t                 u1_r, u2_r, u3_r;
  vec36_t                 y1_r, y2_r, y3_r, y4_r, y5_r, w_r;
  logic signed [PW-1:0]   sum_nxt;
  logic signed [VW-1:0]   d_full;

  always_comb begin
    sum_nxt = PW'(p_r[0]) + PW'(p_r[1]) + PW'(p_r[2]);
    d_full  = rnd30(sum_r);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      p_r[i] <= $signed(in_u[i]) * $signed(in_x[i]);
      q_r[i] <= d_r * $signed(u3_r[i]);
      r_r[i] <= rnd30(q_r[i]);
      w_r[i] <= $signed(y5_r[i]) - r_r[i];
    end
    sum_r <= sum_nxt;
    d_r   <= d_full[DW-1:0];
    u1_r  <= in_u;
    u2_r  <= u1_r;
    u3_r  <= u2_r;
    y1_r  <= in_y;
    y2_r  <= y1_r;
    y3_r  <= y2_r;
    y4_r  <= y3_r;
    y5_r  <= y4_r;
  end

  assign out_valid = vld_r[PROJ_LAT-1];
  assign out_w     = w_r;
  assign out_side  = sd_r[PROJ_LAT-1];

endmodule

`default_nettype wire

### rtl/gram_schmidt_frame_orthonormalize.sv
// Top level of the Gram-Schmidt frame orthonormalizer: three normalizers and
// two projection stages in one pipeline. Uses gsfo_pkg, gsfo_unit, gsfo_proj.
`default_nettype none

// One frame transaction is taken in every clock cycle (busy stays low) and its
// orthonormal frame appears on the out_ ports, marked by out_valid, in order
// and for one cycle only. The path runs through the three normalizers, each 72
// stages long and dominated by a 32-step square root and a 31-step divider,
// plus two of the three 6-stage projection units (the third runs in parallel)
// and the output register. The receiver has no way to stall the pipeline.
module gram_schmidt_frame_orthonormalize import gsfo_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_first_axis_x,
  input  logic signed [31:0] in_first_axis_y,
  input  logic signed [31:0] in_first_axis_z,
  input  logic signed [31:0] in_second_axis_x,
  input  logic signed [31:0] in_second_axis_y,
  input  logic signed [31:0] in_second_axis_z,
  input  logic signed [31:0] in_third_axis_x,
  input  logic signed [31:0] in_third_axis_y,
  input  logic signed [31:0] in_third_axis_z,
  output logic               out_valid,
  output logic signed [31:0] out_unit_first_x,
  output logic signed [31:0] out_unit_first_y,
  output logic signed [31:0] out_unit_first_z,
  output logic signed [31:0] out_unit_second_x,
  output logic signed [31:0] out_unit_second_y,
  output logic signed [31:0] out_unit_second_z,
  output logic signed [31:0] out_unit_third_x,
  output logic signed [31:0] out_unit_third_y,
  output logic signed [31:0] out_unit_third_z,
  output logic               out_degenerate
);

  localparam int TOTAL_LAT = 3 * UNIT_LAT + 2 * PROJ_LAT + 1;

  typedef struct packed {
    vec32_t b;
    vec32_t c;
  } s1_t;

  typedef struct packed {
    vec32_t u1;
    logic   deg;
  } s2_t;

  typedef struct packed {
    vec32_t u1;
    vec32_t c;
    vec36_t wc;
    logic   deg;
  } s3_t;

  typedef struct packed {
    vec32_t u1;
    vec32_t u2;
    logic   deg;
  } s4_t;

  vec32_t a_vec;
  s1_t    s1_in, s1_out;
  logic   u1_vld, u1_zero;
  vec32_t u1_vec;
  s2_t    pb_side_in, pb_side_out;
  logic   pb_vld, pc_vld;
  vec36_t pb_w, pc_w;
  vec32_t pc_side_out;
  s3_t    s3_in, s3_out;
  logic   u2_vld, u2_zero;
  vec32_t u2_vec;
  s4_t    s4_in, s4_mid, s4_out;
  logic   p3_vld, u3_vld, u3_zero;
  vec36_t p3_w;
  vec32_t u3_vec;

  logic   out_valid_r;
  vec32_t f1_r, f2_r, f3_r;
  logic   deg_r;

  assign busy  = 1'b0;
  assign a_vec = {in_first_axis_z, in_first_axis_y, in_first_axis_x};
  assign s1_in.b = {in_second_axis_z, in_second_axis_y, in_second_axis_x};
  assign s1_in.c = {in_third_axis_z, in_third_axis_y, in_third_axis_x};

  gsfo_unit #(.SIDE_W($bits(s1_t))) u_unit1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start && !busy),
    .in_vec    (ext_vec(a_vec)),
    .in_side   (s1_in),
    .out_valid (u1_vld),
    .out_vec   (u1_vec),
    .out_zero  (u1_zero),
    .out_side  (s1_out)
  );

  assign pb_side_in.u1  = u1_vec;
  assign pb_side_in.deg = u1_zero;

  gsfo_proj #(.SIDE_W($bits(s2_t))) u_proj_b (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (u1_vld),
    .in_u      (u1_vec),
    .in_x      (s1_out.b),
    .in_y      (ext_vec(s1_out.b)),
    .in_side   (pb_side_in),
    .out_valid (pb_vld),
    .out_w     (pb_w),
    .out_side  (pb_side_out)
  );

  gsfo_proj #(.SIDE_W($bits(vec32_t))) u_proj_c (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (u1_vld),
    .in_u      (u1_vec),
    .in_x      (s1_out.c),
    .in_y      (ext_vec(s1_out.c)),
    .in_side   (s1_out.c),
    .out_valid (pc_vld),
    .out_w     (pc_w),
    .out_side  (pc_side_out)
  );

  assign s3_in.u1  = pb_side_out.u1;
  assign s3_in.c   = pc_side_out;
  assign s3_in.wc  = pc_w;
  assign s3_in.deg = pb_side_out.deg;

  gsfo_unit #(.SIDE_W($bits(s3_t))) u_unit2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pb_vld && pc_vld),
    .in_vec    (pb_w),
    .in_side   (s3_in),
    .out_valid (u2_vld),
    .out_vec   (u2_vec),
    .out_zero  (u2_zero),
    .out_side  (s3_out)
  );

  assign s4_in.u1  = s3_out.u1;
  assign s4_in.u2  = u2_vec;
  assign s4_in.deg = s3_out.deg | u2_zero;

  gsfo_proj #(.SIDE_W($bits(s4_t))) u_proj_3 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (u2_vld),
    .in_u      (u2_vec),
    .in_x      (s3_out.c),
    .in_y      (s3_out.wc),
    .in_side   (s4_in),
    .out_valid (p3_vld),
    .out_w     (p3_w),
    .out_side  (s4_mid)
  );

  gsfo_unit #(.SIDE_W($bits(s4_t))) u_unit3 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (p3_vld),
    .in_vec    (p3_w),
    .in_side   (s4_mid),
    .out_valid (u3_vld),
    .out_vec   (u3_vec),
    .out_zero  (u3_zero),
    .out_side  (s4_out)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= u3_vld;
    end
  end

  always_ff @(posedge clk) begin
    f1_r  <= s4_out.u1;
    f2_r  <= s4_out.u2;
    f3_r  <= u3_vec;
    deg_r <= s4_out.deg | u3_zero;
  end

  assign out_valid         = out_valid_r;
  assign out_unit_first_x  = f1_r[0];
  assign out_unit_first_y  = f1_r[1];
  assign out_unit_first_z  = f1_r[2];
  assign out_unit_second_x = f2_r[0];
  assign out_unit_second_y = f2_r[1];
  assign out_unit_second_z = f2_r[2];
  assign out_unit_third_x  = f3_r[0];
  assign out_unit_third_y  = f3_r[1];
  assign out_unit_third_z  = f3_r[2];
  assign out_degenerate    = deg_r;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##TOTAL_LAT out_valid)
    else $error("Transaction result did not appear at the expected latency.");

  a_unit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_unit_first_x <= $signed(UNIT_ONE)
               && out_unit_first_x >= $signed(-UNIT_ONE)
               && out_unit_second_y <= $signed(UNIT_ONE)
               && out_unit_second_y >= $signed(-UNIT_ONE)
               && out_unit_third_z <= $signed(UNIT_ONE)
               && out_unit_third_z >= $signed(-UNIT_ONE)))
    else $error("Unit component outside of the range of one.");

  a_degenerate: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_degenerate ==
      ((out_unit_first_x == 0 && out_unit_first_y == 0 && out_unit_first_z == 0)
    || (out_unit_second_x == 0 && out_unit_second_y == 0 && out_unit_second_z == 0)
    || (out_unit_third_x == 0 && out_unit_third_y == 0 && out_unit_third_z == 0))))
    else $error("Degenerate flag does not match the zero axes.");
`endif

endmodule

`default_nettype wire
